[src/solr_pkg.sv]
package solr_pkg;

   // Default configuration of the list.
   localparam int DEPTH_DEF    = 16;
   localparam int ID_WIDTH_DEF = 16;

   // Fixed widths of the transaction fields.
   localparam int ACTION_W   = 3;
   localparam int ITEM_ID_W  = 16;
   localparam int POSITION_W = 4;
   localparam int STATUS_W   = 2;
   localparam int ENTRY_W    = 16;
   localparam int COUNT_W    = 5;

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_TO_TOP    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_TO_BOTTOM = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_STEP_UP   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_STEP_DOWN = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_READ      = 3'd5;

   // Status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                load;
      logic                append;
      logic                set_status;
      logic [STATUS_W-1:0] status_code;
      logic                rd_pos;
      logic                take_entry;
      logic                scan_init;
      logic                scan_rd;
      logic                scan_next;
      logic                shift_rd;
      logic                shift_wr;
      logic                final_wr;
   } solr_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic                full;
      logic                empty;
      logic                pos_bad;
      logic                match;
      logic                scan_last;
      logic                more;
      logic                single;
   } solr_stat_type;

endpackage

[src/solr_if.sv]
// Request channel: one action per transaction.
interface solr_req_if import solr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [ACTION_W-1:0]   action;
   logic [ITEM_ID_W-1:0]  item_id;
   logic [POSITION_W-1:0] position;

   modport source (output valid, output action, output item_id, output position,
                   input ready);
   modport sink (input valid, input action, input item_id, input position,
                 output ready);
endinterface

// Response channel: one result per request.
interface solr_rsp_if import solr_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ENTRY_W-1:0]  entry;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, output status, output entry, output entry_count,
                   input ready);
   modport sink (input valid, input status, input entry, input entry_count,
                 output ready);
endinterface

[src/solr_ram.sv]
module solr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/solr_ctrl.sv]
module solr_ctrl import solr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  solr_stat_type stat,
   output solr_cmd_type  cmd
);

   typedef enum logic [8:0] {
      IDLE       = 9'b000000001,
      DISPATCH   = 9'b000000010,
      SEARCH_RD  = 9'b000000100,
      SEARCH_CMP = 9'b000001000,
      MOVE_CHK   = 9'b000010000,
      MOVE_WR    = 9'b000100000,
      FINAL      = 9'b001000000,
      READ_WAIT  = 9'b010000000,
      RESPOND    = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and the commands issued in each state.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            case (stat.action)
               ACT_APPEND: begin
                  if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_FULL;
                  end else begin
                     cmd.append = 1'b1;
                  end
                  state_in = RESPOND;
               end
               ACT_READ: begin
                  if (stat.pos_bad) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_BAD_POS;
                     state_in        = RESPOND;
                  end else begin
                     cmd.rd_pos = 1'b1;
                     state_in   = READ_WAIT;
                  end
               end
               ACT_TO_TOP, ACT_TO_BOTTOM, ACT_STEP_UP, ACT_STEP_DOWN: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_NOT_FOUND;
                     state_in        = RESPOND;
                  end else begin
                     cmd.scan_init = 1'b1;
                     state_in      = SEARCH_RD;
                  end
               end
               default: begin
                  state_in = RESPOND;
               end
            endcase
         end
         SEARCH_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = SEARCH_CMP;
         end
         SEARCH_CMP: begin
            if (stat.match) begin
               state_in = MOVE_CHK;
            end else if (stat.scan_last) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NOT_FOUND;
               state_in        = RESPOND;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = SEARCH_RD;
            end
         end
         MOVE_CHK: begin
            if (stat.more) begin
               cmd.shift_rd = 1'b1;
               state_in     = MOVE_WR;
            end else begin
               state_in = FINAL;
            end
         end
         MOVE_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = stat.single ? FINAL : MOVE_CHK;
         end
         FINAL: begin
            cmd.final_wr = 1'b1;
            state_in     = RESPOND;
         end
         READ_WAIT: begin
            cmd.take_entry = 1'b1;
            state_in       = RESPOND;
         end
         RESPOND: begin
            if (rsp_ready) begin
               state_in = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == IDLE);
   assign rsp_valid = (state_ff == RESPOND);

endmodule

[src/solr_dpath.sv]
module solr_dpath import solr_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int ID_WIDTH = ID_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [ITEM_ID_W-1:0]  req_item_id,
   input  logic [POSITION_W-1:0] req_position,
   input  solr_cmd_type          cmd,
   output solr_stat_type         stat,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ENTRY_W-1:0]    rsp_entry,
   output logic [COUNT_W-1:0]    rsp_entry_count
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

   logic [ACTION_W-1:0]   action_ff, action_in;
   logic [ID_WIDTH-1:0]   id_ff, id_in;
   logic [POSITION_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic [ENTRY_W-1:0]    entry_ff, entry_in;

   logic                  scan_down;
   logic                  shift_up;
   logic [CNT_W-1:0]      idx_inc;
   logic [ADDR_W-1:0]     idx_up;
   logic [ADDR_W-1:0]     idx_dn;
   logic                  at_top;
   logic                  at_bottom;

   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [ID_WIDTH-1:0]   wr_data;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ID_WIDTH-1:0]   rd_data;

   // Search runs downward only for a move to the bottom; shifts run upward
   // for a move to the top and a step up.
   assign scan_down = (action_ff == ACT_TO_BOTTOM);
   assign shift_up  = (action_ff == ACT_TO_TOP) || (action_ff == ACT_STEP_UP);

   // Neighbor indexes and the edges of the occupied range.
   assign idx_inc   = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_up    = idx_ff + ADDR_W'(1);
   assign idx_dn    = idx_ff - ADDR_W'(1);
   assign at_top    = (idx_inc >= count_ff);
   assign at_bottom = (idx_ff == '0);

   // Status toward the controller.
   always_comb begin
      stat           = '0;
      stat.action    = action_ff;
      stat.full      = (count_ff == CNT_W'(DEPTH));
      stat.empty     = (count_ff == '0);
      stat.pos_bad   = (CMP_W'(pos_ff) >= CMP_W'(count_ff));
      stat.match     = (rd_data == id_ff);
      stat.scan_last = scan_down ? at_bottom : at_top;
      stat.more      = shift_up ? !at_top : !at_bottom;
      stat.single    = (action_ff == ACT_STEP_UP) || (action_ff == ACT_STEP_DOWN);
   end

   // Store port selection.
   always_comb begin
      wr_en   = cmd.append || cmd.shift_wr || cmd.final_wr;
      wr_addr = cmd.append ? ADDR_W'(count_ff) : idx_ff;
      wr_data = cmd.shift_wr ? rd_data : id_ff;
      rd_en   = cmd.rd_pos || cmd.scan_rd || cmd.shift_rd;
      if (cmd.rd_pos) begin
         rd_addr = ADDR_W'(pos_ff);
      end else if (cmd.shift_rd) begin
         rd_addr = shift_up ? idx_up : idx_dn;
      end else begin
         rd_addr = idx_ff;
      end
   end

   // Next values of the working registers.
   always_comb begin
      action_in = action_ff;
      id_in     = id_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      entry_in  = entry_ff;
      if (cmd.load) begin
         action_in = req_action;
         id_in     = ID_WIDTH'(req_item_id);
         pos_in    = req_position;
         status_in = ST_OK;
         entry_in  = '0;
      end
      if (cmd.append) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.take_entry) begin
         entry_in = ENTRY_W'(rd_data);
      end
      if (cmd.scan_init) begin
         idx_in = scan_down ? ADDR_W'(count_ff - CNT_W'(1)) : '0;
      end
      if (cmd.scan_next) begin
         idx_in = scan_down ? idx_dn : idx_up;
      end
      if (cmd.shift_wr) begin
         idx_in = shift_up ? idx_up : idx_dn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff <= action_in;
      id_ff     <= id_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      entry_ff  <= entry_in;
   end

   // Order store.
   solr_ram #(
      .WIDTH (ID_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_status      = status_ff;
   assign rsp_entry       = entry_ff;
   assign rsp_entry_count = COUNT_W'(count_ff);

endmodule

[src/stacking_order_list_reorder_unit.sv]
// Stacking order list with move-to-front style reordering.
// The req_chan channel carries one action per transaction: append, move to
// top, move to bottom, step up, step down or read at a position. The rsp_chan
// channel returns exactly one result per request with a status, the entry read
// and the entry count after the action. Both channels use valid and ready.
// The block works on one request at a time: a request is taken only when the
// previous result has been handed over. An append, an error found at once or an
// unused action is settled in the dispatch state; a read adds a wait state for
// the registered store read. A move searches the store entry by entry, with a
// read and then a compare for each, shifts entries one by one, with a read and
// then a write for each, and ends with a final write of the moved identifier.
// Search and shift together cover at most DEPTH entries. The next request is
// taken once the block is back in idle after the result has been taken.
// Reset empties the list; the store contents are not cleared, since only
// entries below the count are ever read. While the receiver holds rsp ready
// low, the result stays on the channel unchanged and no new request is taken.
module stacking_order_list_reorder_unit import solr_pkg::*; #(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int ID_WIDTH = ID_WIDTH_DEF
) (
   input logic         clock,
   input logic         reset,
   solr_req_if.sink    req_chan,
   solr_rsp_if.source  rsp_chan
);

   solr_cmd_type  cmd;
   solr_stat_type stat;

   // Sequencer.
   solr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Store, index and result registers.
   solr_dpath #(
      .DEPTH    (DEPTH),
      .ID_WIDTH (ID_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_chan.action),
      .req_item_id     (req_chan.item_id),
      .req_position    (req_chan.position),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_status      (rsp_chan.status),
      .rsp_entry       (rsp_chan.entry),
      .rsp_entry_count (rsp_chan.entry_count)
   );

   // A request is never taken while a result is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a result is pending");

   // Any error result carries a zero entry.
   a_err_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != ST_OK) |-> (rsp_chan.entry == '0))
      else $error("error result carries a nonzero entry");

   // A full report comes only with a full list.
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == ST_FULL)
         |-> (rsp_chan.entry_count == COUNT_W'(DEPTH)))
      else $error("full status with a list that is not full");

   // Issuing a store write and a search step together is a sequencing slip.
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.append, cmd.shift_wr, cmd.final_wr, cmd.scan_rd}) <= 1)
      else $error("conflicting store commands");

endmodule

[verif/tb.sv]
module tb import solr_pkg::*; ();

   // Spare action codes that the block must ignore.
   localparam logic [ACTION_W-1:0] ACT_SPARE_6 = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_7 = 3'd7;

   localparam int RANDOM_ITEMS     = 1930;
   localparam int DIRECTED_ROWS    = 23;
   localparam int QUIET_LIMIT      = 2000;
   localparam int TAIL_CYCLES      = 100;
   localparam int LONG_HOLD_AT     = 700;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int BURST_FIRST      = 1000;
   localparam int BURST_LAST       = 1199;
   localparam int REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  entry;
      logic [COUNT_W-1:0]  entry_count;
   } list_result_type;

   typedef struct packed {
      logic [ACTION_W-1:0]   action;
      logic [ITEM_ID_W-1:0]  item_id;
      logic [POSITION_W-1:0] position;
      logic                  use_fixed;
      list_result_type       fixed_result;
   } directed_row_type;

   logic clock;
   logic reset;

   solr_req_if req_if ();
   solr_rsp_if rsp_if ();

   stacking_order_list_reorder_unit #(
      .DEPTH    (DEPTH_DEF),
      .ID_WIDTH (ID_WIDTH_DEF)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // Mirror of the stacking order, updated once per accepted transaction.
   logic [ITEM_ID_W-1:0] mirror_ids [DEPTH_DEF];
   int                   mirror_count = 0;

   list_result_type expected_results [$];
   int              items_sent     = 0;
   int              results_seen   = 0;
   int              mismatch_count = 0;
   int              quiet_cycles   = 0;
   bit              timed_out      = 1'b0;

   // Directed rows: edge cases first, then reordering with a duplicated
   // identifier, whose outcome comes from the mirror.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{ACT_READ,      16'h0000, 4'd0,  1'b1, '{ST_BAD_POS,   16'h0000, 5'd0}},
      '{ACT_TO_TOP,    16'h1234, 4'd0,  1'b1, '{ST_NOT_FOUND, 16'h0000, 5'd0}},
      '{ACT_SPARE_6,   16'hFFFF, 4'd15, 1'b1, '{ST_OK,        16'h0000, 5'd0}},
      '{ACT_APPEND,    16'h0000, 4'd0,  1'b1, '{ST_OK,        16'h0000, 5'd1}},
      '{ACT_STEP_UP,   16'h0000, 4'd0,  1'b1, '{ST_OK,        16'h0000, 5'd1}},
      '{ACT_STEP_DOWN, 16'h0000, 4'd0,  1'b1, '{ST_OK,        16'h0000, 5'd1}},
      '{ACT_APPEND,    16'hFFFF, 4'd0,  1'b1, '{ST_OK,        16'h0000, 5'd2}},
      '{ACT_READ,      16'h0000, 4'd1,  1'b1, '{ST_OK,        16'hFFFF, 5'd2}},
      '{ACT_READ,      16'h0000, 4'd2,  1'b1, '{ST_BAD_POS,   16'h0000, 5'd2}},
      '{ACT_APPEND,    16'h0000, 4'd0,  1'b1, '{ST_OK,        16'h0000, 5'd3}},
      '{ACT_APPEND,    16'h8001, 4'd0,  1'b1, '{ST_OK,        16'h0000, 5'd4}},
      '{ACT_STEP_UP,   16'h8001, 4'd0,  1'b0, '0},
      '{ACT_TO_BOTTOM, 16'h0000, 4'd0,  1'b0, '0},
      '{ACT_TO_TOP,    16'h0000, 4'd0,  1'b0, '0},
      '{ACT_STEP_UP,   16'hFFFF, 4'd0,  1'b0, '0},
      '{ACT_STEP_DOWN, 16'h0000, 4'd0,  1'b0, '0},
      '{ACT_STEP_DOWN, 16'hFFFF, 4'd0,  1'b0, '0},
      '{ACT_READ,      16'h0000, 4'd0,  1'b0, '0},
      '{ACT_READ,      16'h0000, 4'd3,  1'b0, '0},
      '{ACT_TO_BOTTOM, 16'h7777, 4'd0,  1'b1, '{ST_NOT_FOUND, 16'h0000, 5'd4}},
      '{ACT_STEP_UP,   16'h7777, 4'd0,  1'b1, '{ST_NOT_FOUND, 16'h0000, 5'd4}},
      '{ACT_SPARE_7,   16'h5A5A, 4'd3,  1'b1, '{ST_OK,        16'h0000, 5'd4}},
      '{ACT_READ,      16'hFFFF, 4'd15, 1'b1, '{ST_BAD_POS,   16'h0000, 5'd4}}
   };

   // Clock with a period of 12.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Cycles in which neither channel completes a transaction.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Apply one action to the mirror and return the result it produces.
   function automatic list_result_type apply_to_mirror(
         input logic [ACTION_W-1:0]   action,
         input logic [ITEM_ID_W-1:0]  item_id,
         input logic [POSITION_W-1:0] position);
      list_result_type      res;
      int                   hit;
      int                   i;
      logic [ITEM_ID_W-1:0] swap_id;
      res = '0;
      hit = -1;
      // Move to bottom takes the first match from the top; the other moves
      // take the first match from the bottom.
      if (action == ACT_TO_BOTTOM) begin
         for (i = mirror_count - 1; i >= 0; i--) begin
            if (hit < 0 && mirror_ids[i] == item_id) hit = i;
         end
      end else begin
         for (i = 0; i < mirror_count; i++) begin
            if (hit < 0 && mirror_ids[i] == item_id) hit = i;
         end
      end
      case (action)
         ACT_APPEND: begin
            if (mirror_count >= DEPTH_DEF) begin
               res.status = ST_FULL;
            end else begin
               mirror_ids[mirror_count] = item_id;
               mirror_count++;
            end
         end
         ACT_TO_TOP: begin
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               for (i = hit; i + 1 < mirror_count; i++) mirror_ids[i] = mirror_ids[i + 1];
               mirror_ids[mirror_count - 1] = item_id;
            end
         end
         ACT_TO_BOTTOM: begin
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else begin
               for (i = hit; i > 0; i--) mirror_ids[i] = mirror_ids[i - 1];
               mirror_ids[0] = item_id;
            end
         end
         ACT_STEP_UP: begin
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else if (hit + 1 < mirror_count) begin
               swap_id = mirror_ids[hit + 1];
               mirror_ids[hit + 1] = mirror_ids[hit];
               mirror_ids[hit] = swap_id;
            end
         end
         ACT_STEP_DOWN: begin
            if (hit < 0) begin
               res.status = ST_NOT_FOUND;
            end else if (hit > 0) begin
               swap_id = mirror_ids[hit - 1];
               mirror_ids[hit - 1] = mirror_ids[hit];
               mirror_ids[hit] = swap_id;
            end
         end
         ACT_READ: begin
            if (int'(position) >= mirror_count) begin
               res.status = ST_BAD_POS;
            end else begin
               res.entry = mirror_ids[position];
            end
         end
         default: begin
         end
      endcase
      res.entry_count = COUNT_W'(mirror_count);
      return res;
   endfunction

   // Offer one request after a random gap, none in the burst, wait for acceptance,
   // then queue the expected result: the typed one where given, else the mirror's.
   task automatic issue_action(
         input logic [ACTION_W-1:0]   action,
         input logic [ITEM_ID_W-1:0]  item_id,
         input logic [POSITION_W-1:0] position,
         input logic                  use_fixed,
         input list_result_type       fixed_result);
      int              gap;
      list_result_type predicted;
      if (items_sent >= BURST_FIRST && items_sent <= BURST_LAST) begin
         gap = 0;
      end else begin
         gap = $urandom_range(0, 3);
      end
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.action   <= action;
      req_if.item_id  <= item_id;
      req_if.position <= position;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predicted = apply_to_mirror(action, item_id, position);
      expected_results.push_back(use_fixed ? fixed_result : predicted);
      items_sent++;
   endtask

   // Result side: random stalls, one long hold-off, and a stall-free burst.
   initial begin : result_sink
      int              hold;
      list_result_type got;
      list_result_type want;
      rsp_if.ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (results_seen == LONG_HOLD_AT) begin
            hold = LONG_HOLD_CYCLES;
         end else if (results_seen >= BURST_FIRST && results_seen <= BURST_LAST) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 3);
         end
         if (hold != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (rsp_if.valid !== 1'b1) @(posedge clock);
         got = '{rsp_if.status, rsp_if.entry, rsp_if.entry_count};
         results_seen++;
         // Compare the transaction with the oldest expectation.
         if (expected_results.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT) begin
               $display("Unexpected result %0d: status %0d entry %h count %0d",
                        results_seen, got.status, got.entry, got.entry_count);
            end
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (got.status !== want.status || got.entry !== want.entry ||
                got.entry_count !== want.entry_count) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("Mismatch on result %0d: expected status %0d entry %h count %0d",
                           results_seen, want.status, want.entry, want.entry_count);
                  $display("   actual status %0d entry %h count %0d",
                           got.status, got.entry, got.entry_count);
               end
               mismatch_count++;
            end
         end
      end
   end

   // Reset, stimulus, drain and verdict.
   initial begin : main_flow
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.action   <= ACT_APPEND;
      req_if.item_id  <= '0;
      req_if.position <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      fork
         begin : stimulus
            int                    row;
            int                    n;
            int                    roll;
            logic [ACTION_W-1:0]   action;
            logic [ITEM_ID_W-1:0]  item_id;
            for (row = 0; row < DIRECTED_ROWS; row++) begin
               issue_action(directed_rows[row].action, directed_rows[row].item_id,
                            directed_rows[row].position, directed_rows[row].use_fixed,
                            directed_rows[row].fixed_result);
            end
            // Random part: the list fills quickly, then mostly moves of
            // identifiers that are present, some misses and full appends.
            for (n = 0; n < RANDOM_ITEMS; n++) begin
               roll = $urandom_range(0, 99);
               if (mirror_count < DEPTH_DEF && roll < 35) begin
                  action = ACT_APPEND;
               end else begin
                  roll = $urandom_range(0, 99);
                  if (roll < 4) action = ACT_APPEND;
                  else if (roll < 8) action = $urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7;
                  else if (roll < 24) action = ACT_READ;
                  else if (roll < 43) action = ACT_TO_TOP;
                  else if (roll < 62) action = ACT_TO_BOTTOM;
                  else if (roll < 81) action = ACT_STEP_UP;
                  else action = ACT_STEP_DOWN;
               end
               // Identifiers: mostly ones in the list, a small pool that
               // makes duplicates, and some drawn from the whole range.
               roll = $urandom_range(0, 99);
               if (roll < 70 && mirror_count > 0) begin
                  item_id = mirror_ids[$urandom_range(0, mirror_count - 1)];
               end else if (roll < 85) begin
                  item_id = ITEM_ID_W'($urandom_range(0, 7));
               end else begin
                  item_id = ITEM_ID_W'($urandom_range(0, 65535));
               end
               issue_action(action, item_id, POSITION_W'($urandom_range(0, 15)),
                            1'b0, '0);
            end
            req_if.valid <= 1'b0;
            wait (results_seen == items_sent);
            repeat (TAIL_CYCLES) @(posedge clock);
         end
         begin : watchdog
            wait (quiet_cycles >= QUIET_LIMIT);
            timed_out = 1'b1;
         end
      join_any
      if (!timed_out && mismatch_count == 0 && expected_results.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

[filelist.f]
src/solr_pkg.sv
src/solr_if.sv
src/solr_ram.sv
src/solr_ctrl.sv
src/solr_dpath.sv
src/stacking_order_list_reorder_unit.sv
verif/tb.sv
